[src/msm_pkg.sv]
// shared types and constants of the masked temporal pixel smoother
package msm_pkg;

  localparam int PIX_W     = 16;
  localparam int GAIN_W    = 17;
  localparam int FP_W      = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int PROD_W    = PIX_W + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_EN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd2;

  localparam logic [GAIN_W-1:0] INTENSITY_RST    = 17'd6554;
  localparam logic [FP_W-1:0]   FRAME_PIXELS_RST = 20'd307200;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              mask_en;
    logic [FP_W-1:0]   frame_pixels;
  } cfg_t;

endpackage

[src/msm_cfg.sv]
// configuration registers with gain saturation
module msm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output msm_pkg::cfg_t                    cfg
);

  logic [msm_pkg::GAIN_W-1:0] intensity_r;
  logic                       mask_en_r;
  logic [msm_pkg::FP_W-1:0]   frame_pixels_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r    <= msm_pkg::INTENSITY_RST;
      mask_en_r      <= 1'b0;
      frame_pixels_r <= msm_pkg::FRAME_PIXELS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        msm_pkg::REG_INTENSITY:    intensity_r    <= cfg_data[msm_pkg::GAIN_W-1:0];
        msm_pkg::REG_MASK_EN:      mask_en_r      <= cfg_data[0];
        msm_pkg::REG_FRAME_PIXELS: frame_pixels_r <= cfg_data[msm_pkg::FP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.gain         = (intensity_r > msm_pkg::GAIN_ONE) ? msm_pkg::GAIN_ONE : intensity_r;
    cfg.mask_en      = mask_en_r;
    cfg.frame_pixels = frame_pixels_r;
  end

endmodule

[src/msm_seq.sv]
// frame position counter and first-frame flag
module msm_seq #(
  parameter int MAX_PIXELS = 524288,
  parameter int ADDR_W     = 19
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [msm_pkg::FP_W-1:0]   frame_pixels,
  output logic [ADDR_W-1:0]          idx,
  output logic                       last,
  output logic                       first
);

  localparam int CW = ((msm_pkg::FP_W > ADDR_W) ? msm_pkg::FP_W : ADDR_W) + 2;

  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              first_r, first_nxt;
  logic [CW-1:0]     fp_ext, size, next_ext;

  always_comb begin
    fp_ext   = CW'(frame_pixels);
    if (fp_ext == '0)
      size = CW'(1);
    else if (fp_ext > CW'(MAX_PIXELS))
      size = CW'(MAX_PIXELS);
    else
      size = fp_ext;
    next_ext = CW'(idx_r) + CW'(1);
    last     = (next_ext >= size);
    idx      = idx_r;
    first    = first_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    if (step) begin
      if (last) begin
        idx_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        idx_nxt = next_ext[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      first_r <= 1'b1;
    end else begin
      idx_r   <= idx_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

[src/msm_store.sv]
// frame store memory with registered read and last-write forwarding
module msm_store #(
  parameter int MAX_PIXELS = 524288,
  parameter int ADDR_W     = 19
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  msm_pkg::pix_t        wr_data,
  output msm_pkg::pix_t        prev
);

  msm_pkg::pix_t     mem [MAX_PIXELS];
  msm_pkg::pix_t     rd_q_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              lw_valid_r;
  logic [ADDR_W-1:0] lw_addr_r;
  msm_pkg::pix_t     lw_data_r;

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      lw_valid_r <= 1'b0;
    else if (wr_en)
      lw_valid_r <= 1'b1;
  end

  // a write landing on the read edge is not seen by the array read
  assign prev = (lw_valid_r && (lw_addr_r == rd_addr_r)) ? lw_data_r : rd_q_r;

endmodule

[src/msm_calc.sv]
// moving-average update of one pixel
module msm_calc (
  input  msm_pkg::pix_t               prev,
  input  msm_pkg::pix_t               cur,
  input  logic [msm_pkg::GAIN_W-1:0]  gain,
  input  logic                        hold,
  input  logic                        first,
  output msm_pkg::pix_t               result
);

  logic                        up;
  msm_pkg::pix_t               mag;
  logic [msm_pkg::PROD_W-1:0]  prod;
  msm_pkg::pix_t               step;

  always_comb begin
    up   = (cur >= prev);
    mag  = up ? (cur - prev) : (prev - cur);
    prod = msm_pkg::PROD_W'(mag) * msm_pkg::PROD_W'(gain);
    step = prod[msm_pkg::PIX_W+15:16];
    if (first)
      result = cur;
    else if (hold)
      result = prev;
    else if (up)
      result = prev + step;
    else
      result = prev - step;
  end

endmodule

[src/masked_temporal_pixel_smoother_core.sv]
// top level of the masked temporal pixel smoother
// an input beat is registered into stage 1 with its store read, then into the
//   output register, where its output beat is offered until out_tready takes it
// throughput: one beat per cycle while out_tready holds high, sustained by
//   a read-modify-write loop through the store's forwarding register and the 16x17 multiplier
// reset: counters, valid flags and configuration return to defaults; the frame
//   store is not cleared, the first frame after reset initializes it
module masked_temporal_pixel_smoother_core #(
  parameter int MAX_PIXELS = 524288
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // pixel_in
  input  logic                            in_tuser,   // motion_bit
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // pixel_out
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [msm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  msm_pkg::cfg_t     cfg;
  logic              adv, in_fire, s1_fire;
  logic [ADDR_W-1:0] seq_idx;
  logic              seq_last, seq_first;
  msm_pkg::pix_t     prev, result;

  logic              s1_valid_r;
  msm_pkg::pix_t     s1_pix_r;
  logic              s1_motion_r;
  logic [ADDR_W-1:0] s1_idx_r;
  logic              s1_last_r;
  logic              s1_first_r;

  logic              out_valid_r;
  msm_pkg::pix_t     out_pix_r;
  logic              out_last_r;

  msm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign adv       = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  msm_seq #(
    .MAX_PIXELS (MAX_PIXELS),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .frame_pixels (cfg.frame_pixels),
    .idx          (seq_idx),
    .last         (seq_last),
    .first        (seq_first)
  );

  msm_store #(
    .MAX_PIXELS (MAX_PIXELS),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (seq_idx),
    .wr_en   (s1_fire),
    .wr_addr (s1_idx_r),
    .wr_data (result),
    .prev    (prev)
  );

  msm_calc u_calc (
    .prev   (prev),
    .cur    (s1_pix_r),
    .gain   (cfg.gain),
    .hold   (cfg.mask_en && !s1_motion_r),
    .first  (s1_first_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)
        s1_valid_r <= 1'b1;
      else if (s1_fire)
        s1_valid_r <= 1'b0;
      if (adv)
        out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r    <= in_tdata;
      s1_motion_r <= in_tuser;
      s1_idx_r    <= seq_idx;
      s1_last_r   <= seq_last;
      s1_first_r  <= seq_first;
    end
    if (s1_fire) begin
      out_pix_r  <= result;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

[tb/masked_temporal_pixel_smoother_core_test.sv]
// self-checking testbench for the masked temporal pixel smoother core
module masked_temporal_pixel_smoother_core_test;
  import msm_pkg::*;

  localparam int STORE_DEPTH = 524288;
  localparam int PIXEL_BUDGET = 1450;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    pix_t pixel;
    bit   last;
  } smoothed_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // pixel_in
  logic                  in_tuser = 1'b0; // motion_bit
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;       // pixel_out
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  masked_temporal_pixel_smoother_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [GAIN_W-1:0] gain_reg = INTENSITY_RST;
  logic              mask_reg = 1'b0;
  logic [FP_W-1:0]   frame_reg = FRAME_PIXELS_RST;
  pix_t              pixel_store [int];
  int                pix_idx = 0;
  bit                first_frame = 1'b1;
  int                filled = 0;
  smoothed_t         smoothed_q [$];

  int  mismatches = 0;
  int  pixels_sent = 0;
  int  results_seen = 0;
  int  frames_seen = 0;
  int  reg_writes = 0;
  int  stall_left = 0;
  bit  steady = 1'b0;

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int frame_size();
    int n;
    n = int'(frame_reg);
    if (n == 0) n = 1;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    return n;
  endfunction

  function automatic pix_t smooth_toward(pix_t prev, pix_t cur);
    longint unsigned g;
    longint unsigned mag;
    g = (gain_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_reg);
    if (cur >= prev) begin
      mag = (longint'(cur) - longint'(prev)) * g;
      return prev + pix_t'(mag >> 16);
    end
    mag = (longint'(prev) - longint'(cur)) * g;
    return prev - pix_t'(mag >> 16);
  endfunction

  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return pix_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic predict_smoothed(input pix_t cur, input bit motion);
    smoothed_t r;
    int size;
    int idx;
    pix_t prev;
    size = frame_size();
    idx = pix_idx;
    if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;
    if (first_frame) begin
      r.pixel = cur;
    end else begin
      prev = pixel_store[idx];
      if (mask_reg && !motion) r.pixel = prev;
      else r.pixel = smooth_toward(prev, cur);
    end
    pixel_store[idx] = r.pixel;
    if (idx >= filled) filled = idx + 1;
    r.last = (idx + 1 >= size);
    if (r.last) begin
      pix_idx = 0;
      first_frame = 1'b0;
    end else begin
      pix_idx = idx + 1;
    end
    smoothed_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_beat();
    smoothed_t want;
    if (smoothed_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat data=%h last=%b", out_tdata, out_tlast));
    end else begin
      want = smoothed_q.pop_front();
      if (out_tdata !== want.pixel)
        report_mismatch($sformatf("pixel_out %h, wanted %h", out_tdata, want.pixel));
      if (out_tlast !== want.last)
        report_mismatch($sformatf("frame_last %b, wanted %b", out_tlast, want.last));
      if (want.last) frames_seen++;
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_beat();
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  task automatic send_pixel(input pix_t pix, input bit motion);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= motion;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_smoothed(pix, motion);
    pixels_sent++;
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INTENSITY:    gain_reg = data[GAIN_W-1:0];
      REG_MASK_EN:      mask_reg = data[0];
      REG_FRAME_PIXELS: frame_reg = data[FP_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // first frame copies through, ignores the mask, and ends early on a shrink
  task automatic test_first_frame();
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    write_reg(REG_FRAME_PIXELS, 20'hFFFFF);
    write_reg(REG_MASK_EN, 20'd1);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0001, 1'b1);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b1);
    send_pixel(16'h00FF, 1'b0);
    write_reg(REG_FRAME_PIXELS, 20'd5);
    send_pixel(16'hC3C3, 1'b0);
  endtask

  task automatic test_default_gain();
    write_reg(REG_MASK_EN, 20'd0);
    write_reg(REG_FRAME_PIXELS, 20'd4);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b1);
  endtask

  task automatic test_gain_extremes();
    write_reg(REG_INTENSITY, 20'd0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    write_reg(REG_INTENSITY, 20'h10000);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    write_reg(REG_INTENSITY, 20'hFFFFF);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h8001, 1'b0);
  endtask

  task automatic test_mask_gate();
    write_reg(REG_INTENSITY, 20'h08000);
    write_reg(REG_MASK_EN, 20'hFFFFF);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b1);
  endtask

  task automatic test_zero_frame();
    write_reg(REG_FRAME_PIXELS, 20'd0);
    send_pixel(16'h4321, 1'b1);
    send_pixel(16'hBEEF, 1'b1);
  endtask

  task automatic test_unused_register();
    write_reg(REG_UNUSED, 20'hFFFFF);
    send_pixel(16'h0F0F, 1'b1);
    send_pixel(16'hF0F0, 1'b0);
  endtask

  task automatic test_random_phases();
    int n;
    logic [CFG_DATA_W-1:0] data;
    while (pixels_sent < PIXEL_BUDGET) begin
      steady = ($urandom_range(0, 4) == 0);
      data = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 5))
        0: data[GAIN_W-1:0] = '0;
        1: data[GAIN_W-1:0] = GAIN_ONE;
        2: data[GAIN_W-1:0] = GAIN_W'($urandom_range(65537, 131071));
        3: data[GAIN_W-1:0] = INTENSITY_RST;
        default: data[GAIN_W-1:0] = GAIN_W'($urandom_range(1, 65535));
      endcase
      write_reg(REG_INTENSITY, data);
      write_reg(REG_MASK_EN, CFG_DATA_W'($urandom));
      case ($urandom_range(0, 5))
        0: data = '0;
        1: data = 20'd1;
        2: data = CFG_DATA_W'(filled);
        default: data = CFG_DATA_W'($urandom_range(1, filled));
      endcase
      write_reg(REG_FRAME_PIXELS, data);
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      n = $urandom_range(40, 150);
      repeat (n) send_pixel(pick_pixel(), 1'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_frame();
    test_default_gain();
    test_gain_extremes();
    test_mask_gate();
    test_zero_frame();
    test_unused_register();
    test_random_phases();
    wait_quiet();
    repeat (8) @(posedge clk);
    $display("sent %0d pixels over %0d register writes, %0d frames closed",
             pixels_sent, reg_writes, frames_seen);
    $display("checked %0d output beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("masked_temporal_pixel_smoother_core verification clean");
    end else begin
      $display("masked_temporal_pixel_smoother_core verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d beats outstanding", smoothed_q.size());
    $display("masked_temporal_pixel_smoother_core verification failed");
    $finish;
  end

endmodule

[sim.f]
src/msm_pkg.sv
src/msm_cfg.sv
src/msm_seq.sv
src/msm_store.sv
src/msm_calc.sv
src/masked_temporal_pixel_smoother_core.sv
tb/masked_temporal_pixel_smoother_core_test.sv
